// ===== hw/rtl/lfuct_pkg.sv =====
package lfuct_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam int KEY_W = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 16;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [VALUE_W-1:0] read_value;
   } rsp_type;

endpackage

// ===== hw/rtl/lfu_cache_table_unit.sv =====
// lfu cache table, one request at a time, entries swept through one ram port
// result: strobe is registered out of the decide step that follows the scan pass
// passes: a get miss or a put at zero capacity takes the scan pass only; a get hit
// or a put at nonzero capacity adds a rank update pass
// reset: synchronous, clears valid marks, sequencer and capacity (16); results never stall
module lfu_cache_table_unit #(
   parameter int TABLE_DEPTH = lfuct_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  lfuct_pkg::req_type                req_data,
   output logic                              rsp_strobe,
   output lfuct_pkg::rsp_type                rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfuct_pkg::CAP_W-1:0]       csr_data
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int RW = IW;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int CMPW = (CW > lfuct_pkg::CAP_W) ? CW : lfuct_pkg::CAP_W;
   localparam int KW = lfuct_pkg::KEY_W;
   localparam int VW = lfuct_pkg::VALUE_W;
   localparam int NW = lfuct_pkg::COUNT_W;

   typedef struct packed {
      logic signed [KW-1:0] key;
      logic signed [VW-1:0] value;
      logic [NW-1:0]        count;
      logic [RW-1:0]        rank;
   } entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_UPDATE
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in;
   lfuct_pkg::req_type req_ff, req_in;
   logic               found_ff, found_in;
   logic [IW-1:0]      slot_ff, slot_in;
   logic [RW-1:0]      slot_rank_ff, slot_rank_in;
   logic [NW-1:0]      slot_count_ff, slot_count_in;
   logic [VW-1:0]      slot_value_ff, slot_value_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic               free_found_ff, free_found_in;
   logic [IW-1:0]      free_idx_ff, free_idx_in;
   logic               vic_found_ff, vic_found_in;
   logic [IW-1:0]      vic_idx_ff, vic_idx_in;
   logic [RW-1:0]      vic_rank_ff, vic_rank_in;
   logic [NW-1:0]      vic_count_ff, vic_count_in;
   logic               upd_touch_ff, upd_touch_in;
   logic               upd_insert_ff, upd_insert_in;
   logic               upd_evict_ff, upd_evict_in;
   logic [IW-1:0]      tgt_idx_ff, tgt_idx_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [lfuct_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   lfuct_pkg::rsp_type rsp_ff, rsp_in;

   logic               mem_we;
   logic [IW-1:0]      mem_wr_addr;
   entry_type          mem_wr_data;
   entry_type          mem_rd_data;

   logic               ent_valid;
   logic               is_put;
   logic               cap_nz;
   logic               fill_ge_cap;
   logic               do_touch;
   logic               do_insert;
   logic               do_evict;
   logic [IW-1:0]      ins_idx;

   lfuct_entry_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (IW),
      .DATA_W ($bits(entry_type))
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (mem_rd_data)
   );

   assign ent_valid = valid_ff[rd_idx_ff];
   assign is_put = (req_ff.kind == lfuct_pkg::KIND_PUT);
   assign cap_nz = (cap_ff != '0);
   assign fill_ge_cap = (CMPW'(fill_ff) >= CMPW'(cap_ff)) || (fill_ff == CW'(TABLE_DEPTH));
   assign do_touch = found_ff && (!is_put || cap_nz);
   assign do_insert = !found_ff && is_put && cap_nz;
   assign do_evict = do_insert && fill_ge_cap;
   assign ins_idx = (do_evict && !(free_found_ff && (free_idx_ff < vic_idx_ff))) ?
                    vic_idx_ff : free_idx_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = cnt_ff[IW-1:0];
      req_in        = req_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      slot_rank_in  = slot_rank_ff;
      slot_count_in = slot_count_ff;
      slot_value_in = slot_value_ff;
      fill_in       = fill_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      vic_found_in  = vic_found_ff;
      vic_idx_in    = vic_idx_ff;
      vic_rank_in   = vic_rank_ff;
      vic_count_in  = vic_count_ff;
      upd_touch_in  = upd_touch_ff;
      upd_insert_in = upd_insert_ff;
      upd_evict_in  = upd_evict_ff;
      tgt_idx_in    = tgt_idx_ff;
      valid_in      = valid_ff;
      cap_in        = cap_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_wr_addr   = rd_idx_ff;
      mem_wr_data   = mem_rd_data;

      if (csr_valid) begin
         cap_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in        = req_data;
               found_in      = 1'b0;
               fill_in       = '0;
               free_found_in = 1'b0;
               vic_found_in  = 1'b0;
               cnt_in        = '0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cnt_ff != CW'(TABLE_DEPTH)) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + CW'(1);
            end else begin
               state_in = S_DECIDE;
            end
            if (rd_vld_ff) begin
               fill_in = fill_ff + CW'(ent_valid);
               if (ent_valid && (mem_rd_data.key == req_ff.key) && !found_ff) begin
                  found_in      = 1'b1;
                  slot_in       = rd_idx_ff;
                  slot_rank_in  = mem_rd_data.rank;
                  slot_count_in = mem_rd_data.count;
                  slot_value_in = mem_rd_data.value;
               end
               if (!ent_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
               if (ent_valid && (!vic_found_ff || (mem_rd_data.count < vic_count_ff) ||
                   ((mem_rd_data.count == vic_count_ff) &&
                    (mem_rd_data.rank > vic_rank_ff)))) begin
                  vic_found_in = 1'b1;
                  vic_idx_in   = rd_idx_ff;
                  vic_rank_in  = mem_rd_data.rank;
                  vic_count_in = mem_rd_data.count;
               end
            end
         end
         S_DECIDE: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.hit        = found_ff;
            rsp_in.read_value = (!is_put && found_ff) ? slot_value_ff : '1;
            upd_touch_in      = do_touch;
            upd_insert_in     = do_insert;
            upd_evict_in      = do_evict;
            tgt_idx_in        = do_touch ? slot_ff : ins_idx;
            if (do_evict) begin
               valid_in[vic_idx_ff] = 1'b0;
            end
            if (do_insert) begin
               valid_in[ins_idx] = 1'b1;
            end
            cnt_in   = '0;
            state_in = (do_touch || do_insert) ? S_UPDATE : S_IDLE;
         end
         S_UPDATE: begin
            if (cnt_ff != CW'(TABLE_DEPTH)) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + CW'(1);
            end else begin
               state_in = S_IDLE;
            end
            if (rd_vld_ff) begin
               if (rd_idx_ff == tgt_idx_ff) begin
                  mem_we            = 1'b1;
                  mem_wr_data.key   = req_ff.key;
                  mem_wr_data.value = (upd_insert_ff || is_put) ? req_ff.value : slot_value_ff;
                  mem_wr_data.rank  = '0;
                  if (upd_insert_ff) begin
                     mem_wr_data.count = NW'(1);
                  end else if (slot_count_ff == '1) begin
                     mem_wr_data.count = slot_count_ff;
                  end else begin
                     mem_wr_data.count = slot_count_ff + NW'(1);
                  end
               end else if (ent_valid) begin
                  mem_we = 1'b1;
                  if (upd_touch_ff) begin
                     if (mem_rd_data.rank < slot_rank_ff) begin
                        mem_wr_data.rank = mem_rd_data.rank + RW'(1);
                     end
                  end else if (!(upd_evict_ff && (mem_rd_data.rank > vic_rank_ff))) begin
                     mem_wr_data.rank = mem_rd_data.rank + RW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      rd_idx_ff     <= rd_idx_in;
      req_ff        <= req_in;
      found_ff      <= found_in;
      slot_ff       <= slot_in;
      slot_rank_ff  <= slot_rank_in;
      slot_count_ff <= slot_count_in;
      slot_value_ff <= slot_value_in;
      fill_ff       <= fill_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      vic_found_ff  <= vic_found_in;
      vic_idx_ff    <= vic_idx_in;
      vic_rank_ff   <= vic_rank_in;
      vic_count_ff  <= vic_count_in;
      upd_touch_ff  <= upd_touch_in;
      upd_insert_ff <= upd_insert_in;
      upd_evict_ff  <= upd_evict_in;
      tgt_idx_ff    <= tgt_idx_in;
      rsp_ff        <= rsp_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_vld_ff     <= 1'b0;
         valid_ff      <= '0;
         cap_ff        <= lfuct_pkg::CAP_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         valid_ff      <= valid_in;
         cap_ff        <= cap_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // one result beat per request, only right after the decision step
   a_rsp_after_decide: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_DECIDE))
      else $error("result beat without a decision step");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result beat longer than one cycle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_SCAN))
      else $error("accepted request did not start a scan");

   a_update_needed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> (upd_touch_ff || upd_insert_ff))
      else $error("update pass without a hit or insert");

   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.hit) |-> (rsp_data.read_value == '1))
      else $error("miss returned a value other than minus one");

endmodule

// ===== hw/rtl/lfuct_entry_ram.sv =====
module lfuct_entry_ram #(
   parameter int DEPTH  = lfuct_pkg::TABLE_DEPTH_DEFAULT,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 84
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/lfu_cache_table_unit_tb.sv =====
`timescale 1ns / 1ps

module lfu_cache_table_unit_tb;

   localparam int DEPTH = lfuct_pkg::TABLE_DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPLY_SLOTS = 8;
   localparam logic [31:0] KEY_MIN = 32'h8000_0000;
   localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;
   localparam logic [15:0] COUNT_TOP = 16'hFFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   lfuct_pkg::req_type req_data = '0;
   logic rsp_strobe;
   lfuct_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [lfuct_pkg::CAP_W-1:0] csr_data = '0;

   // shadow copy of the cache contents
   logic        ent_valid [DEPTH];
   logic [31:0] ent_key [DEPTH];
   logic [31:0] ent_value [DEPTH];
   logic [15:0] ent_count [DEPTH];
   logic [3:0]  ent_rank [DEPTH];
   logic [lfuct_pkg::CAP_W-1:0] shadow_capacity = lfuct_pkg::CAP_RESET;

   // ring of expected result beats
   lfuct_pkg::rsp_type awaited_replies [REPLY_SLOTS];
   int sent_count = 0;
   int seen_count = 0;
   int error_count = 0;
   int cycle_count = 0;

   lfu_cache_table_unit #(.TABLE_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lfu_cache_table_unit_tb: errors");
         $finish;
      end
   end

   function automatic void touch_entry(int slot);
      if (ent_count[slot] != COUNT_TOP)
         ent_count[slot] = ent_count[slot] + 16'd1;
      for (int i = 0; i < DEPTH; i++)
         if (ent_valid[i] && i != slot && ent_rank[i] < ent_rank[slot])
            ent_rank[i] = ent_rank[i] + 4'd1;
      ent_rank[slot] = 4'd0;
   endfunction

   function automatic lfuct_pkg::rsp_type model_cache_access(lfuct_pkg::req_type rq);
      lfuct_pkg::rsp_type rs;
      int slot;
      int free_slot;
      int victim;
      int fill;
      int cap;
      slot = -1;
      free_slot = -1;
      victim = -1;
      fill = 0;
      cap = (shadow_capacity > DEPTH) ? DEPTH : int'(shadow_capacity);
      rs.read_value = '1;
      for (int i = 0; i < DEPTH; i++)
         if (slot < 0 && ent_valid[i] && ent_key[i] == rq.key)
            slot = i;
      if (rq.kind == lfuct_pkg::KIND_GET) begin
         if (slot >= 0) begin
            touch_entry(slot);
            rs.read_value = ent_value[slot];
         end
      end else if (cap != 0) begin
         if (slot >= 0) begin
            ent_value[slot] = rq.value;
            touch_entry(slot);
         end else begin
            for (int i = 0; i < DEPTH; i++)
               if (ent_valid[i])
                  fill++;
            if (fill >= cap) begin
               for (int i = 0; i < DEPTH; i++)
                  if (ent_valid[i] && (victim < 0 || ent_count[i] < ent_count[victim] ||
                      (ent_count[i] == ent_count[victim] && ent_rank[i] > ent_rank[victim])))
                     victim = i;
               if (victim >= 0) begin
                  for (int i = 0; i < DEPTH; i++)
                     if (ent_valid[i] && ent_rank[i] > ent_rank[victim])
                        ent_rank[i] = ent_rank[i] - 4'd1;
                  ent_valid[victim] = 1'b0;
               end
            end
            for (int i = 0; i < DEPTH; i++)
               if (free_slot < 0 && !ent_valid[i])
                  free_slot = i;
            if (free_slot >= 0) begin
               for (int i = 0; i < DEPTH; i++)
                  if (ent_valid[i])
                     ent_rank[i] = ent_rank[i] + 4'd1;
               ent_valid[free_slot] = 1'b1;
               ent_key[free_slot] = rq.key;
               ent_value[free_slot] = rq.value;
               ent_count[free_slot] = 16'd1;
               ent_rank[free_slot] = 4'd0;
            end
         end
      end
      rs.hit = (slot >= 0);
      return rs;
   endfunction

   always @(posedge clock) begin
      lfuct_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (sent_count == seen_count) begin
            $error("result beat with no request waiting: hit %0d read_value %0h",
                   rsp_data.hit, rsp_data.read_value);
            error_count++;
         end else begin
            want = awaited_replies[seen_count % REPLY_SLOTS];
            seen_count++;
            if (rsp_data.hit !== want.hit) begin
               $error("hit expected %0d actual %0d", want.hit, rsp_data.hit);
               error_count++;
            end
            if (rsp_data.read_value !== want.read_value) begin
               $error("read_value expected %0h actual %0h", want.read_value,
                      rsp_data.read_value);
               error_count++;
            end
         end
      end
   end

   task automatic send_request(input logic kind, input logic [31:0] key,
                               input logic [31:0] value, input bit quiet);
      lfuct_pkg::req_type rq;
      int gap;
      rq.kind = kind;
      rq.key = key;
      rq.value = value;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         @(posedge clock);
         while (busy) @(posedge clock);
      end
      repeat (gap + 1) @(posedge clock);
      start <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      awaited_replies[sent_count % REPLY_SLOTS] = model_cache_access(rq);
      sent_count++;
      start <= 1'b0;
   endtask

   task automatic drain_replies();
      while (sent_count != seen_count) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [lfuct_pkg::CAP_W-1:0] cap);
      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_capacity = cap;
      csr_valid <= 1'b0;
   endtask

   task automatic test_basic_access();
      send_request(lfuct_pkg::KIND_GET, KEY_MIN, 32'h1234_5678, 1'b0);
      send_request(lfuct_pkg::KIND_PUT, KEY_MIN, KEY_MAX, 1'b0);
      send_request(lfuct_pkg::KIND_PUT, KEY_MAX, KEY_MIN, 1'b1);
      send_request(lfuct_pkg::KIND_GET, KEY_MIN, 32'h0, 1'b0);
      send_request(lfuct_pkg::KIND_PUT, KEY_MAX, 32'h0, 1'b1);
      send_request(lfuct_pkg::KIND_GET, 32'h0, 32'hFFFF_FFFF, 1'b0);
      send_request(lfuct_pkg::KIND_PUT, 32'h0, 32'hFFFF_FFFF, 1'b0);
      send_request(lfuct_pkg::KIND_GET, 32'h0, 32'h0, 1'b1);
   endtask

   // counts tie at the first eviction, so the oldest entry goes first
   task automatic test_tie_break_eviction();
      write_capacity(5'd2);
      send_request(lfuct_pkg::KIND_PUT, 32'd5, 32'hA5A5_A5A5, 1'b0);
      send_request(lfuct_pkg::KIND_GET, KEY_MIN, 32'h0, 1'b0);
      send_request(lfuct_pkg::KIND_PUT, 32'd6, 32'h5A5A_5A5A, 1'b1);
      send_request(lfuct_pkg::KIND_GET, 32'd5, 32'h0, 1'b0);
   endtask

   task automatic test_zero_capacity();
      write_capacity(5'd0);
      send_request(lfuct_pkg::KIND_PUT, 32'd6, 32'hDEAD_BEEF, 1'b0);
      send_request(lfuct_pkg::KIND_PUT, 32'd7, 32'h0BAD_F00D, 1'b1);
      send_request(lfuct_pkg::KIND_GET, 32'd6, 32'h0, 1'b0);
      send_request(lfuct_pkg::KIND_GET, 32'd7, 32'h0, 1'b0);
   endtask

   // table stays above capacity, one eviction per missing put
   task automatic test_capacity_shrink();
      write_capacity(5'd31);
      send_request(lfuct_pkg::KIND_PUT, 32'd8, 32'h1, 1'b0);
      send_request(lfuct_pkg::KIND_PUT, 32'd9, 32'h2, 1'b1);
      write_capacity(5'd1);
      send_request(lfuct_pkg::KIND_PUT, 32'd10, 32'h3, 1'b0);
      send_request(lfuct_pkg::KIND_GET, 32'd8, 32'h0, 1'b0);
   endtask

   task automatic test_random_traffic();
      int phase_caps [12] = '{16, 1, 31, 0, 2, 4, 17, 8, 3, 15, 16, 0};
      logic [31:0] key_pool [24];
      int pool_size;
      int put_pct;
      bit quiet;
      logic [31:0] key;
      for (int p = 0; p < 12; p++) begin
         write_capacity((p == 11) ? 5'($urandom_range(0, 31)) : 5'(phase_caps[p]));
         pool_size = $urandom_range(2, 24);
         put_pct = $urandom_range(30, 70);
         quiet = 1'b0;
         for (int i = 0; i < 24; i++)
            key_pool[i] = $urandom;
         if ($urandom_range(0, 1) == 0)
            key_pool[$urandom_range(0, pool_size - 1)] = KEY_MIN;
         if ($urandom_range(0, 1) == 0)
            key_pool[$urandom_range(0, pool_size - 1)] = KEY_MAX;
         for (int n = 0; n < 105; n++) begin
            if (n % 20 == 0)
               quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 39) == 0)
               drain_replies();
            key = ($urandom_range(0, 6) == 0) ? 32'($urandom)
                                              : key_pool[$urandom_range(0, pool_size - 1)];
            send_request(($urandom_range(0, 99) < put_pct) ? lfuct_pkg::KIND_PUT
                                                           : lfuct_pkg::KIND_GET,
                         key, 32'($urandom), quiet);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         ent_valid[i] = 1'b0;
         ent_key[i] = '0;
         ent_value[i] = '0;
         ent_count[i] = '0;
         ent_rank[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_basic_access();
      test_tie_break_eviction();
      test_zero_capacity();
      test_capacity_shrink();
      test_random_traffic();
      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && sent_count == seen_count) begin
         $display("lfu_cache_table_unit_tb: clean");
      end else begin
         if (sent_count != seen_count)
            $error("%0d results never arrived", sent_count - seen_count);
         $display("lfu_cache_table_unit_tb: errors");
      end
      $finish;
   end

endmodule
